/* rtl/bap_pkg.sv */
// shared constants, register codes and control types for the block average pixelate block
// no dependencies

package bap_pkg;

	// default limits handed to the top level parameters
	localparam int MAX_WIDTH_DEF = 2048;
	localparam int MAX_TILE_DEF  = 64;
	// image height is bounded by the 11-bit row position
	localparam int MAX_HEIGHT    = 2048;

	// stream word widths
	localparam int PIX_W   = 8;
	localparam int IN_W    = 24;
	localparam int OUT_W   = 48;
	localparam int IDX_W   = 11;

	// configuration port
	localparam int CFG_AW  = 2;
	localparam int CFG_DW  = 12;
	localparam int DIM_W   = 12;
	localparam int TSIZE_W = 7;

	localparam logic [DIM_W-1:0]   WIDTH_RST  = 12'd640;
	localparam logic [DIM_W-1:0]   HEIGHT_RST = 12'd480;
	localparam logic [TSIZE_W-1:0] TSIZE_RST  = 7'd12;

	// depth of the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// quotient bits of the rounded mean
	localparam int QBITS = 8;

	typedef enum logic [CFG_AW-1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1,
		REG_TILE_SIZE    = 2'd2
	} bap_reg_t;

	// classification of one pixel, made by the front
	typedef struct packed {
		logic seg_start;   // first pixel of a tile within this row
		logic band_first;  // pixel lies on the first row of a tile band
		logic seg_end;     // last pixel of a tile within this row
		logic emit;        // last pixel of the whole (clipped) tile
		logic frame_last;  // last pixel of the frame
	} bap_flags_t;

endpackage

/* rtl/bap_ram.sv */
// generic simple dual port ram, one write and one registered read port
// no dependencies

module bap_ram #(
	parameter int W     = 60,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);

	logic [W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/bap_fifo.sv */
// short flop based queue between the front and the back
// depends on nothing but its parameters (depth a power of two)

module bap_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  buf_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign dout  = buf_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/bap_front.sv */
// front: configuration registers, raster position tracking and pixel classification
// depends on bap_pkg

module bap_front #(
	parameter int MAX_WIDTH = bap_pkg::MAX_WIDTH_DEF,
	parameter int MAX_TILE  = bap_pkg::MAX_TILE_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      cfg_we,
	input  logic [bap_pkg::CFG_AW-1:0]                cfg_addr,
	input  logic [bap_pkg::CFG_DW-1:0]                cfg_wdata,
	input  logic                                      s_tvalid,
	output logic                                      s_tready,
	input  logic [bap_pkg::IN_W-1:0]                  s_tdata,
	input  logic                                      full,
	output logic                                      push,
	output logic [bap_pkg::IN_W-1:0]                  push_pix,
	output logic [$clog2(MAX_WIDTH)-1:0]              push_tc,
	output logic [bap_pkg::IDX_W-1:0]                 push_col,
	output logic [bap_pkg::IDX_W-1:0]                 push_row,
	output logic [2*$clog2(MAX_TILE):0]               push_n,
	output bap_pkg::bap_flags_t                       push_flags
);

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int TW = $clog2(MAX_TILE);
	localparam int NW = 2 * TW + 1;
	localparam int YW = bap_pkg::IDX_W;
	localparam int HW = bap_pkg::DIM_W;

	logic [bap_pkg::DIM_W-1:0]   width_q;
	logic [bap_pkg::DIM_W-1:0]   height_q;
	logic [bap_pkg::TSIZE_W-1:0] tsize_q;

	logic [XW-1:0] pix_x_q;
	logic [YW-1:0] pix_y_q;
	logic [TW-1:0] cit_q;
	logic [TW-1:0] rit_q;
	logic [XW-1:0] tcol_q;
	logic [YW-1:0] trow_q;

	logic [XW:0]      w_eff;
	logic [HW-1:0]    h_eff;
	logic [TW:0]      t_eff;
	logic             row_end;
	logic             col_last;
	logic             bottom;
	logic             row_last;
	logic             restart;
	logic [TW:0]      cnt_c;
	logic [TW:0]      cnt_r;
	logic [2*TW+1:0]  n_full;

	// zero acts as one, oversize is clipped
	always_comb begin
		if (width_q == '0) begin
			w_eff = (XW+1)'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			w_eff = (XW+1)'(MAX_WIDTH);
		end else begin
			w_eff = (XW+1)'(width_q);
		end
		if (height_q == '0) begin
			h_eff = HW'(1);
		end else if (32'(height_q) > bap_pkg::MAX_HEIGHT) begin
			h_eff = HW'(bap_pkg::MAX_HEIGHT);
		end else begin
			h_eff = height_q;
		end
		if (tsize_q == '0) begin
			t_eff = (TW+1)'(1);
		end else if (32'(tsize_q) > MAX_TILE) begin
			t_eff = (TW+1)'(MAX_TILE);
		end else begin
			t_eff = (TW+1)'(tsize_q);
		end
	end

	assign cnt_c    = {1'b0, cit_q} + (TW+1)'(1);
	assign cnt_r    = {1'b0, rit_q} + (TW+1)'(1);
	assign row_end  = ({1'b0, pix_x_q} + (XW+1)'(1)) >= w_eff;
	assign col_last = row_end || (cnt_c >= t_eff);
	assign bottom   = (HW'(pix_y_q) + HW'(1)) >= h_eff;
	assign row_last = bottom || (cnt_r >= t_eff);
	assign n_full   = cnt_c * cnt_r;

	assign s_tready = !full;
	assign push     = s_tvalid && !full;

	assign push_pix              = s_tdata;
	assign push_tc               = tcol_q;
	assign push_col              = bap_pkg::IDX_W'(tcol_q);
	assign push_row              = trow_q;
	assign push_n                = NW'(n_full);
	assign push_flags.seg_start  = (cit_q == '0);
	assign push_flags.band_first = (rit_q == '0);
	assign push_flags.seg_end    = col_last;
	assign push_flags.emit       = col_last && row_last;
	assign push_flags.frame_last = row_end && bottom;

	always_comb begin
		case (cfg_addr)
			bap_pkg::REG_IMAGE_WIDTH:  restart = cfg_we;
			bap_pkg::REG_IMAGE_HEIGHT: restart = cfg_we;
			bap_pkg::REG_TILE_SIZE:    restart = cfg_we;
			default:                   restart = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bap_pkg::WIDTH_RST;
			height_q <= bap_pkg::HEIGHT_RST;
			tsize_q  <= bap_pkg::TSIZE_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				bap_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_wdata;
				bap_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_wdata;
				bap_pkg::REG_TILE_SIZE:    tsize_q  <= cfg_wdata[bap_pkg::TSIZE_W-1:0];
				default:                   width_q  <= width_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_x_q <= '0;
			pix_y_q <= '0;
			cit_q   <= '0;
			rit_q   <= '0;
			tcol_q  <= '0;
			trow_q  <= '0;
		end else if (restart) begin
			pix_x_q <= '0;
			pix_y_q <= '0;
			cit_q   <= '0;
			rit_q   <= '0;
			tcol_q  <= '0;
			trow_q  <= '0;
		end else if (push) begin
			if (row_end) begin
				pix_x_q <= '0;
				cit_q   <= '0;
				tcol_q  <= '0;
				if (bottom) begin
					pix_y_q <= '0;
					rit_q   <= '0;
					trow_q  <= '0;
				end else begin
					pix_y_q <= pix_y_q + YW'(1);
					if (row_last) begin
						rit_q  <= '0;
						trow_q <= trow_q + YW'(1);
					end else begin
						rit_q  <= rit_q + TW'(1);
					end
				end
			end else begin
				pix_x_q <= pix_x_q + XW'(1);
				if (col_last) begin
					cit_q  <= '0;
					tcol_q <= tcol_q + XW'(1);
				end else begin
					cit_q  <= cit_q + TW'(1);
				end
			end
		end
	end

endmodule

/* rtl/bap_accum.sv */
// back, first half: per tile column accumulation with a column sum memory
// depends on bap_pkg and bap_ram

module bap_accum #(
	parameter int MAX_WIDTH = bap_pkg::MAX_WIDTH_DEF,
	parameter int MAX_TILE  = bap_pkg::MAX_TILE_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          adv,
	input  logic                                          in_valid,
	input  logic [bap_pkg::IN_W-1:0]                      in_pix,
	input  logic [$clog2(MAX_WIDTH)-1:0]                  in_tc,
	input  logic [bap_pkg::IDX_W-1:0]                     in_col,
	input  logic [bap_pkg::IDX_W-1:0]                     in_row,
	input  logic [2*$clog2(MAX_TILE):0]                   in_n,
	input  bap_pkg::bap_flags_t                           in_flags,
	output logic                                          out_valid,
	output logic [2:0][bap_pkg::PIX_W+2*$clog2(MAX_TILE)-1:0] out_sum,
	output logic [2*$clog2(MAX_TILE):0]                   out_n,
	output logic [bap_pkg::IDX_W-1:0]                     out_col,
	output logic [bap_pkg::IDX_W-1:0]                     out_row,
	output logic                                          out_last
);

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int TW = $clog2(MAX_TILE);
	localparam int NW = 2 * TW + 1;
	localparam int SW = bap_pkg::PIX_W + 2 * TW;
	localparam int PW = bap_pkg::PIX_W;

	logic                            v_s1;
	logic [bap_pkg::IN_W-1:0]        pix_s1;
	logic [XW-1:0]                   tc_s1;
	logic [bap_pkg::IDX_W-1:0]       col_s1;
	logic [bap_pkg::IDX_W-1:0]       row_s1;
	logic [NW-1:0]                   n_s1;
	bap_pkg::bap_flags_t             flags_s1;

	logic                            v_s2;
	logic [bap_pkg::IN_W-1:0]        pix_s2;
	logic [XW-1:0]                   tc_s2;
	logic [bap_pkg::IDX_W-1:0]       col_s2;
	logic [bap_pkg::IDX_W-1:0]       row_s2;
	logic [NW-1:0]                   n_s2;
	bap_pkg::bap_flags_t             flags_s2;

	logic [2:0][SW-1:0]              acc_q;
	logic [2:0][SW-1:0]              acc_new;
	logic [2:0][SW-1:0]              fwd_d_q;
	logic                            fwd_q;
	logic [2:0][SW-1:0]              rdata;
	logic                            ram_re;
	logic                            ram_we;

	// column sum is only fetched when a later row of the band resumes a tile
	assign ram_re = adv && v_s1 && flags_s1.seg_start && !flags_s1.band_first;
	// the final row of a tile hands its sum on, later rows start again from zero
	assign ram_we = adv && v_s2 && flags_s2.seg_end && !flags_s2.emit;

	bap_ram #(
		.W     (3 * SW),
		.DEPTH (MAX_WIDTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tc_s2),
		.wdata (acc_new),
		.re    (ram_re),
		.raddr (tc_s1),
		.rdata (rdata)
	);

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			if (!flags_s2.seg_start) begin
				acc_new[c] = acc_q[c] + SW'(pix_s2[c*PW +: PW]);
			end else if (flags_s2.band_first) begin
				acc_new[c] = SW'(pix_s2[c*PW +: PW]);
			end else if (fwd_q) begin
				acc_new[c] = fwd_d_q[c] + SW'(pix_s2[c*PW +: PW]);
			end else begin
				acc_new[c] = rdata[c] + SW'(pix_s2[c*PW +: PW]);
			end
		end
	end

	assign out_valid = v_s2 && flags_s2.emit;
	assign out_sum   = acc_new;
	assign out_n     = n_s2;
	assign out_col   = col_s2;
	assign out_row   = row_s2;
	assign out_last  = flags_s2.frame_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			fwd_q <= 1'b0;
		end else if (adv) begin
			v_s1  <= in_valid;
			v_s2  <= v_s1;
			// read and write of the same column in one cycle: take the new value
			fwd_q <= ram_re && ram_we && (tc_s2 == tc_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s1   <= in_pix;
			tc_s1    <= in_tc;
			col_s1   <= in_col;
			row_s1   <= in_row;
			n_s1     <= in_n;
			flags_s1 <= in_flags;
			pix_s2   <= pix_s1;
			tc_s2    <= tc_s1;
			col_s2   <= col_s1;
			row_s2   <= row_s1;
			n_s2     <= n_s1;
			flags_s2 <= flags_s1;
			fwd_d_q  <= acc_new;
			if (v_s2) begin
				acc_q <= acc_new;
			end
		end
	end

endmodule

/* rtl/bap_div.sv */
// back, second half: pipelined restoring division for the rounded tile means
// depends on bap_pkg

module bap_div #(
	parameter int MAX_TILE = bap_pkg::MAX_TILE_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          adv,
	input  logic                                          in_valid,
	input  logic [2:0][bap_pkg::PIX_W+2*$clog2(MAX_TILE)-1:0] in_sum,
	input  logic [2*$clog2(MAX_TILE):0]                   in_n,
	input  logic [bap_pkg::IDX_W-1:0]                     in_col,
	input  logic [bap_pkg::IDX_W-1:0]                     in_row,
	input  logic                                          in_last,
	output logic                                          out_valid,
	output logic [2:0][bap_pkg::PIX_W-1:0]                out_avg,
	output logic [bap_pkg::IDX_W-1:0]                     out_col,
	output logic [bap_pkg::IDX_W-1:0]                     out_row,
	output logic                                          out_last
);

	localparam int TW = $clog2(MAX_TILE);
	localparam int NW = 2 * TW + 1;
	localparam int SW = bap_pkg::PIX_W + 2 * TW;
	localparam int DW = SW + 1;
	localparam int VW = NW + 1;
	localparam int QB = bap_pkg::QBITS;

	logic                          v_s    [QB+1];
	logic [2:0][DW-1:0]            rem_s  [QB+1];
	logic [2:0][QB-1:0]            q_s    [QB+1];
	logic [VW-1:0]                 dv_s   [QB+1];
	logic [bap_pkg::IDX_W-1:0]     col_s  [QB+1];
	logic [bap_pkg::IDX_W-1:0]     row_s  [QB+1];
	logic                          last_s [QB+1];

	// entry: dividend 2*sum + n, divisor 2*n
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (adv) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 3; c++) begin
				rem_s[0][c] <= {in_sum[c], 1'b0} + DW'(in_n);
			end
			q_s[0]    <= '0;
			dv_s[0]   <= {in_n, 1'b0};
			col_s[0]  <= in_col;
			row_s[0]  <= in_row;
			last_s[0] <= in_last;
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar k = 0; k < QB; k++) begin : g_step
		localparam int B = QB - 1 - k;

		logic [DW-1:0]      shv;
		logic [2:0][DW-1:0] rem_nx;
		logic [2:0][QB-1:0] q_nx;

		assign shv = DW'(dv_s[k]) << B;

		always_comb begin
			for (int c = 0; c < 3; c++) begin
				q_nx[c] = q_s[k][c];
				if (rem_s[k][c] >= shv) begin
					rem_nx[c]  = rem_s[k][c] - shv;
					q_nx[c][B] = 1'b1;
				end else begin
					rem_nx[c]  = rem_s[k][c];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (adv) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k+1]  <= rem_nx;
				q_s[k+1]    <= q_nx;
				dv_s[k+1]   <= dv_s[k];
				col_s[k+1]  <= col_s[k];
				row_s[k+1]  <= row_s[k];
				last_s[k+1] <= last_s[k];
			end
		end
	end

	assign out_valid = v_s[QB];
	assign out_avg   = q_s[QB];
	assign out_col   = col_s[QB];
	assign out_row   = row_s[QB];
	assign out_last  = last_s[QB];

endmodule

/* rtl/block_average_pixelate_top.sv */
// top level of the block average pixelate block: mosaic tile means over a raster stream
// depends on bap_pkg, bap_front, bap_fifo, bap_accum, bap_div (and bap_ram below them)

// usage
//  - pixels come in on the s_ channel in raster order, one word per pixel, blue in the
//    lowest byte; each accepted word is one pixel of the current frame
//  - one word leaves on the m_ channel for every finished (edge clipped) tile, carrying
//    the tile column and row and the rounded mean of each colour; m_tlast marks the
//    frame's final tile, after which the position wraps to the top left corner
//  - throughput is one pixel per clock while m_tready does not stall the back pipeline;
//    the front and the accumulator take a word every cycle, and the division is fully
//    pipelined: a tile's last pixel passes the queue, two accumulator stages, the
//    divider entry and eight quotient stages on its way to m_tvalid
//  - a stalled m_tready freezes the whole back pipeline with the word held on m_tdata;
//    the four deep queue then fills and s_tready drops until the receiver moves again
//  - configuration goes through cfg_we/cfg_addr/cfg_wdata while the block is idle;
//    any write to a listed register restarts the frame at pixel zero
//  - reset loads 640 x 480 with 12 pixel tiles and clears all positions; the column
//    sum memory needs no clearing pass, since the first row of each tile band starts
//    every sum afresh and the memory is only read on later rows of a band

module block_average_pixelate_top #(
	parameter int MAX_WIDTH = bap_pkg::MAX_WIDTH_DEF,
	parameter int MAX_TILE  = bap_pkg::MAX_TILE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write port
	input  logic                          cfg_we,
	input  logic [bap_pkg::CFG_AW-1:0]    cfg_addr,
	input  logic [bap_pkg::CFG_DW-1:0]    cfg_wdata,
	// pixel stream in
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [bap_pkg::IN_W-1:0]      s_tdata,   // blue[7:0], green[15:8], red[23:16]
	// tile stream out
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [bap_pkg::OUT_W-1:0]     m_tdata,   // tile_col[10:0], tile_row[21:11],
	                                                 // avg_blue[29:22], avg_green[37:30],
	                                                 // avg_red[45:38], zero[47:46]
	output logic                          m_tlast    // frame_last
);

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int TW = $clog2(MAX_TILE);
	localparam int NW = 2 * TW + 1;
	localparam int SW = bap_pkg::PIX_W + 2 * TW;
	localparam int FW = $bits(bap_pkg::bap_flags_t);
	localparam int QW = bap_pkg::IN_W + XW + 2 * bap_pkg::IDX_W + NW + FW;

	// front side of the queue
	logic                        push;
	logic                        q_full;
	logic [bap_pkg::IN_W-1:0]    f_pix;
	logic [XW-1:0]               f_tc;
	logic [bap_pkg::IDX_W-1:0]   f_col;
	logic [bap_pkg::IDX_W-1:0]   f_row;
	logic [NW-1:0]               f_n;
	bap_pkg::bap_flags_t         f_flags;

	// back side of the queue
	logic                        q_empty;
	logic                        pop;
	logic [QW-1:0]               q_dout;
	logic [bap_pkg::IN_W-1:0]    b_pix;
	logic [XW-1:0]               b_tc;
	logic [bap_pkg::IDX_W-1:0]   b_col;
	logic [bap_pkg::IDX_W-1:0]   b_row;
	logic [NW-1:0]               b_n;
	bap_pkg::bap_flags_t         b_flags;

	// accumulator to divider
	logic                        a_valid;
	logic [2:0][SW-1:0]          a_sum;
	logic [NW-1:0]               a_n;
	logic [bap_pkg::IDX_W-1:0]   a_col;
	logic [bap_pkg::IDX_W-1:0]   a_row;
	logic                        a_last;

	// divider output register
	logic                        d_valid;
	logic [2:0][bap_pkg::PIX_W-1:0] d_avg;
	logic [bap_pkg::IDX_W-1:0]   d_col;
	logic [bap_pkg::IDX_W-1:0]   d_row;
	logic                        d_last;

	// whole back pipeline moves when the output word is empty or being taken
	logic                        adv;

	assign adv = !d_valid || m_tready;
	assign pop = adv && !q_empty;

	bap_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_TILE  (MAX_TILE)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.full       (q_full),
		.push       (push),
		.push_pix   (f_pix),
		.push_tc    (f_tc),
		.push_col   (f_col),
		.push_row   (f_row),
		.push_n     (f_n),
		.push_flags (f_flags)
	);

	bap_fifo #(
		.W     (QW),
		.DEPTH (bap_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    ({f_pix, f_tc, f_col, f_row, f_n, f_flags}),
		.full   (q_full),
		.pop    (pop),
		.dout   (q_dout),
		.empty  (q_empty)
	);

	assign {b_pix, b_tc, b_col, b_row, b_n, b_flags} = q_dout;

	bap_accum #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_TILE  (MAX_TILE)
	) u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (!q_empty),
		.in_pix    (b_pix),
		.in_tc     (b_tc),
		.in_col    (b_col),
		.in_row    (b_row),
		.in_n      (b_n),
		.in_flags  (b_flags),
		.out_valid (a_valid),
		.out_sum   (a_sum),
		.out_n     (a_n),
		.out_col   (a_col),
		.out_row   (a_row),
		.out_last  (a_last)
	);

	bap_div #(
		.MAX_TILE (MAX_TILE)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (a_valid),
		.in_sum    (a_sum),
		.in_n      (a_n),
		.in_col    (a_col),
		.in_row    (a_row),
		.in_last   (a_last),
		.out_valid (d_valid),
		.out_avg   (d_avg),
		.out_col   (d_col),
		.out_row   (d_row),
		.out_last  (d_last)
	);

	// output word packing, lowest field first
	assign m_tvalid = d_valid;
	assign m_tdata  = {2'b00, d_avg[2], d_avg[1], d_avg[0], d_row, d_col};
	assign m_tlast  = d_last;

endmodule

/* rtl/bap_checker.sv */
// port level checks for the block average pixelate top level, bound to it below
// depends on bap_pkg and block_average_pixelate_top

module bap_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tready,
	input  logic                      m_tvalid,
	input  logic                      m_tready,
	input  logic [bap_pkg::OUT_W-1:0] m_tdata,
	input  logic                      m_tlast
);

	// a stalled result word keeps its content, tlast included
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result word changed while stalled");

	// once reset has been seen at an edge, no result is offered at the next one
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !m_tvalid)
		else $error("result offered during reset");

	// padding above the red mean stays zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[bap_pkg::OUT_W-1:bap_pkg::OUT_W-2] == 2'b00))
		else $error("padding bits set in result word");

	// the first cycle out of reset has no result yet, the pipeline is empty
	a_empty_after_reset: assert property (@(posedge clk)
		$rose(arst_n) |=> !m_tvalid)
		else $error("result appeared straight after reset");

	// input side is free to take a word while the queue drains on a moving output
	a_ready_returns: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready && m_tready |=> ##1 s_tready || m_tvalid)
		else $error("input side stuck while output moves");

endmodule

bind block_average_pixelate_top bap_checker u_bap_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

/* bench/tb_block_average_pixelate_top.sv */
// self-checking bench for block_average_pixelate_top: raster pixels in, tile means out
// depends on bap_pkg and block_average_pixelate_top, predicts every tile word locally
`timescale 1ns / 100ps

module tb_block_average_pixelate_top;
	import bap_pkg::*;

	// geometry limits of the default build
	localparam int COL_DEPTH  = MAX_WIDTH_DEF;
	localparam int TILE_LIMIT = MAX_TILE_DEF;
	localparam int ROW_LIMIT  = MAX_HEIGHT;

	// index past the register list, writes there must be ignored
	localparam logic [CFG_AW-1:0] REG_SPARE = 2'd3;

	// quiet time after the last tile word before touching the registers
	localparam int SETTLE_CYCLES  = 20;
	// cycles with no word moving on either side before the run is abandoned
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_PIXELS  = 800;
	// longest random burst, bigger frames are cut short and restarted
	localparam int BURST_CAP      = 400;

	typedef struct packed {
		logic [IDX_W-1:0] tile_col;
		logic [IDX_W-1:0] tile_row;
		logic [PIX_W-1:0] avg_blue;
		logic [PIX_W-1:0] avg_green;
		logic [PIX_W-1:0] avg_red;
		logic             frame_last;
	} tile_mean_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              cfg_we    = 1'b0;
	logic [CFG_AW-1:0] cfg_addr  = '0;
	logic [CFG_DW-1:0] cfg_wdata = '0;
	logic              s_tvalid  = 1'b0;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata   = '0;   // blue[7:0], green[15:8], red[23:16]
	logic              m_tvalid;
	logic              m_tready  = 1'b0;
	logic [OUT_W-1:0]  m_tdata;          // tile_col, tile_row, avg_blue, avg_green, avg_red
	logic              m_tlast;          // frame_last

	// no idling on either side while set
	logic steady_flow = 1'b0;

	// local copy of the registers and of the mosaic state
	logic [DIM_W-1:0]   model_width  = WIDTH_RST;
	logic [DIM_W-1:0]   model_height = HEIGHT_RST;
	logic [TSIZE_W-1:0] model_tile   = TSIZE_RST;
	logic [19:0]        col_sum_blue  [COL_DEPTH];
	logic [19:0]        col_sum_green [COL_DEPTH];
	logic [19:0]        col_sum_red   [COL_DEPTH];
	int unsigned        pos_x, pos_y, row_in, col_in;

	tile_mean_t  tile_means_due[$];
	tile_mean_t  due_tile;
	int unsigned mismatch_count = 0;
	int unsigned stalled_cycles = 0;
	int unsigned stall_left     = 0;
	int unsigned ready_roll;

	block_average_pixelate_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------- prediction

	// a zero register acts as one, an oversized one as the limit
	function automatic int unsigned effective_dim(input int unsigned v, input int unsigned hi);
		if (v == 0) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	// round to nearest, ties upward
	function automatic logic [7:0] rounded_mean(input longint unsigned total,
			input longint unsigned n);
		return 8'((2 * total + n) / (2 * n));
	endfunction

	// frame restart: positions to the top left corner, all column sums cleared
	task automatic clear_mosaic_state();
		int i;
		for (i = 0; i < COL_DEPTH; i++) begin
			col_sum_blue[i]  = '0;
			col_sum_green[i] = '0;
			col_sum_red[i]   = '0;
		end
		pos_x  = 0;
		pos_y  = 0;
		row_in = 0;
		col_in = 0;
	endtask

	// adds one accepted pixel to its tile column, queues the tile mean on the tile's last pixel
	task automatic accumulate_pixel(input logic [IN_W-1:0] px);
		int unsigned w, h, t, tc, n;
		bit          row_end, col_last, bottom, row_last;
		tile_mean_t  tm;
		w = effective_dim(model_width, COL_DEPTH);
		h = effective_dim(model_height, ROW_LIMIT);
		t = effective_dim(model_tile, TILE_LIMIT);
		tc       = (pos_x / t) % COL_DEPTH;
		row_end  = (pos_x + 1 >= w);
		col_last = row_end || (col_in + 1 >= t);
		bottom   = (pos_y + 1 >= h);
		row_last = bottom || (row_in + 1 >= t);
		col_sum_blue[tc]  = col_sum_blue[tc] + px[7:0];
		col_sum_green[tc] = col_sum_green[tc] + px[15:8];
		col_sum_red[tc]   = col_sum_red[tc] + px[23:16];
		if (col_last && row_last) begin
			// clipped pixel count of this tile
			n = (col_in + 1) * (row_in + 1);
			tm.tile_col   = IDX_W'(pos_x / t);
			tm.tile_row   = IDX_W'(pos_y / t);
			tm.avg_blue   = rounded_mean(col_sum_blue[tc], n);
			tm.avg_green  = rounded_mean(col_sum_green[tc], n);
			tm.avg_red    = rounded_mean(col_sum_red[tc], n);
			tm.frame_last = row_end && bottom;
			tile_means_due.push_back(tm);
			col_sum_blue[tc]  = '0;
			col_sum_green[tc] = '0;
			col_sum_red[tc]   = '0;
		end
		if (row_end) begin
			pos_x  = 0;
			col_in = 0;
			if (bottom) begin
				// end of frame, wrap to the corner
				pos_y  = 0;
				row_in = 0;
			end else begin
				pos_y++;
				row_in = row_last ? 0 : row_in + 1;
			end
		end else begin
			pos_x++;
			col_in = col_last ? 0 : col_in + 1;
		end
	endtask

	// ---------------------------------------------------------------- stimulus helpers

	// mostly back to back, some short gaps, a few long ones
	function automatic int unsigned pick_gap();
		int unsigned roll;
		if (steady_flow) return 0;
		roll = $urandom_range(0, 99);
		if (roll < 65) return 0;
		if (roll < 95) return $urandom_range(1, 3);
		return $urandom_range(20, 60);
	endfunction

	// random colour with a share of all black and all white pixels
	function automatic logic [IN_W-1:0] random_pixel();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 8) return 24'h000000;
		if (roll < 16) return 24'hFFFFFF;
		return IN_W'($urandom);
	endfunction

	// offers one pixel word and holds it until taken
	task automatic send_pixel(input logic [IN_W-1:0] px);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= px;
		do @(posedge clk); while (!s_tready);
		accumulate_pixel(px);
	endtask

	// sender holds off until every predicted tile word has come out
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (tile_means_due.size() != 0);
	endtask

	// drained, then enough quiet cycles for pixels that make no tile word to clear the pipe
	task automatic wait_idle();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// one register write, taken on the next edge; cfg_we is lowered by the caller
	task automatic write_register(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
		cfg_we    <= 1'b1;
		cfg_addr  <= addr;
		cfg_wdata <= data;
		@(posedge clk);
	endtask

	// writes the registers picked by mask (bit per register index) once the block is idle
	task automatic program_block(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
			input logic [TSIZE_W-1:0] t, input logic [3:0] mask);
		wait_idle();
		if (mask[REG_IMAGE_WIDTH]) begin
			write_register(REG_IMAGE_WIDTH, w);
			model_width = w;
		end
		if (mask[REG_IMAGE_HEIGHT]) begin
			write_register(REG_IMAGE_HEIGHT, h);
			model_height = h;
		end
		if (mask[REG_TILE_SIZE]) begin
			write_register(REG_TILE_SIZE, t);
			model_tile = t;
		end
		// past the list: no effect, the frame carries on
		if (mask[REG_SPARE])
			write_register(REG_SPARE, CFG_DW'($urandom));
		cfg_we <= 1'b0;
		// any listed register restarts the frame
		if (mask[2:0] != 3'b000)
			clear_mosaic_state();
	endtask

	// ---------------------------------------------------------------- tests

	// reset width 640 and 12 pixel tiles over a single row: 53 full tiles, last clipped to 4
	task automatic test_reset_geometry();
		int unsigned k;
		program_block(12'd0, 12'd1, 7'd0, 4'b0010);
		for (k = 0; k < WIDTH_RST; k++)
			send_pixel(random_pixel());
	endtask

	// 5 x 3 image of 2 pixel tiles: clipped right column and bottom row, ties rounding upward,
	// channel extremes, frame end and wrap
	task automatic test_clipped_tiles();
		int unsigned i;
		logic [7:0]  b, g, r;
		program_block(12'd5, 12'd3, 7'd2, 4'b0111);
		for (i = 0; i < 15; i++) begin
			b = i[0] ? 8'hFF : 8'h00;
			g = i[1] ? 8'h01 : 8'h00;
			r = (i == 14) ? 8'hFF : 8'(i * 17);
			send_pixel({r, g, b});
		end
	endtask

	// a write past the register list leaves the frame alone, a listed one restarts it
	task automatic test_restart_and_spare();
		int unsigned k;
		program_block(12'd2, 12'd2, 7'd2, 4'b0111);
		for (k = 0; k < 2; k++)
			send_pixel(random_pixel());
		program_block(12'd0, 12'd0, 7'd0, 4'b1000);
		send_pixel(random_pixel());
		program_block(12'd2, 12'd2, 7'd2, 4'b0010);
		for (k = 0; k < 4; k++)
			send_pixel(random_pixel());
	endtask

	// zero and oversized registers: a one pixel wide column with tiles cut to 64 rows,
	// a single row with oversized tiles cut to 64 columns, then a zero tile size acting
	// as single pixel tiles
	task automatic test_dimension_limits();
		int unsigned k;
		program_block(12'd0, 12'hFFF, 7'h7F, 4'b0111);
		for (k = 0; k < 2 * TILE_LIMIT + 2; k++)
			send_pixel(random_pixel());
		program_block(12'hFFF, 12'd0, 7'd100, 4'b0111);
		for (k = 0; k < 3 * TILE_LIMIT; k++)
			send_pixel(random_pixel());
		program_block(12'd3, 12'd2, 7'd0, 4'b0111);
		for (k = 0; k < 6; k++)
			send_pixel(random_pixel());
	endtask

	// random small geometries: mostly whole frames, some cut short by a restart,
	// now and then a pause until every tile word is out
	task automatic test_random_mosaics();
		int unsigned        sent, frame_px, burst, pause_at, roll, k;
		logic [DIM_W-1:0]   w, h;
		logic [TSIZE_W-1:0] t;
		logic [3:0]         mask;
		sent = 0;
		while (sent < RANDOM_PIXELS) begin
			roll = $urandom_range(0, 99);
			if (roll < 5)
				w = 12'd0;
			else if (roll < 12)
				w = DIM_W'($urandom_range(40, 70));
			else
				w = DIM_W'($urandom_range(1, 24));
			h = ($urandom_range(0, 19) == 0) ? 12'd0 : DIM_W'($urandom_range(1, 12));
			roll = $urandom_range(0, 99);
			if (roll < 10)
				t = 7'd0;
			else if (roll < 60)
				t = TSIZE_W'($urandom_range(1, 6));
			else if (roll < 85)
				t = TSIZE_W'($urandom_range(7, 20));
			else if (roll < 93)
				t = 7'd64;
			else
				t = TSIZE_W'($urandom_range(65, 127));
			roll = $urandom_range(0, 99);
			if (roll < 85)
				mask = {1'($urandom_range(0, 1)), 3'b111};
			else if (roll < 95)
				mask = 4'($urandom_range(0, 15));
			else
				mask = 4'b0000;
			if (mask != 4'b0000)
				program_block(w, h, t, mask);
			steady_flow <= ($urandom_range(0, 3) == 0);
			frame_px = effective_dim(model_width, COL_DEPTH) *
				effective_dim(model_height, ROW_LIMIT);
			if ($urandom_range(0, 9) < 7)
				burst = frame_px * $urandom_range(1, 2);
			else
				burst = $urandom_range(1, 2 * frame_px);
			if (burst > BURST_CAP)
				burst = BURST_CAP;
			pause_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, burst - 1) : burst;
			for (k = 0; k < burst; k++) begin
				if (k == pause_at)
					wait_drained();
				send_pixel(random_pixel());
				sent++;
			end
		end
	endtask

	// ---------------------------------------------------------------- receiver and checker

	// receiver: mostly ready, short stalls, the odd long one
	always @(posedge clk) begin
		if (steady_flow) begin
			m_tready <= 1'b1;
			stall_left = 0;
		end else if (stall_left != 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			ready_roll = $urandom_range(0, 99);
			if (ready_roll < 70) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b0;
				stall_left = (ready_roll < 95) ? $urandom_range(0, 2) : $urandom_range(19, 59);
			end
		end
	end

	task automatic check_field(input string what, input logic [IDX_W-1:0] want,
			input logic [IDX_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d actual %0d", $time, what, want, got);
			mismatch_count++;
		end
	endtask

	// each tile word against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (tile_means_due.size() == 0) begin
				$display("%0t: tile word expected none actual col %0d row %0d", $time,
					m_tdata[10:0], m_tdata[21:11]);
				mismatch_count++;
			end else begin
				due_tile = tile_means_due.pop_front();
				check_field("tile_col", due_tile.tile_col, m_tdata[10:0]);
				check_field("tile_row", due_tile.tile_row, m_tdata[21:11]);
				check_field("avg_blue", due_tile.avg_blue, m_tdata[29:22]);
				check_field("avg_green", due_tile.avg_green, m_tdata[37:30]);
				check_field("avg_red", due_tile.avg_red, m_tdata[45:38]);
				check_field("frame_last", due_tile.frame_last, m_tlast);
			end
		end
	end

	// watchdog: too long with no word moving on either side
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stalled_cycles <= 0;
		end else if (stalled_cycles == WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			stalled_cycles <= stalled_cycles + 1;
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		clear_mosaic_state();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_geometry();
		test_clipped_tiles();
		test_restart_and_spare();
		test_dimension_limits();
		test_random_mosaics();
		// everything out, then the settle time for stray words
		wait_idle();
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

/* sim.f */
rtl/bap_pkg.sv
rtl/bap_ram.sv
rtl/bap_fifo.sv
rtl/bap_front.sv
rtl/bap_accum.sv
rtl/bap_div.sv
rtl/block_average_pixelate_top.sv
rtl/bap_checker.sv
bench/tb_block_average_pixelate_top.sv
